// ===== design/cfi_pkg.sv =====
// Shared types and constants for the calibrated feedforward interpolator.
// No dependencies.
package cfi_pkg;

   localparam int POINTS_DEFAULT = 16;
   localparam int VAL_W          = 16;
   localparam int NUM_TABLES     = 4;
   localparam int QUOT_W         = 16;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } command_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] drive;
      logic signed [VAL_W-1:0] speed;
   } point_type;

   typedef struct packed {
      logic              start;
      logic [QUOT_W-1:0] num;
      logic [QUOT_W-1:0] den;
   } div_req_type;

endpackage

// ===== design/calibrated_feedforward_interpolator.sv =====
// Top level: request FSM, table walk over cfi_store, interpolation via cfi_div.
// Depends on cfi_pkg, cfi_store, cfi_div.
//
// A load beat with an in-range index writes one calibration point in the
// cycle it is accepted and yields no response. An evaluate beat walks the
// selected table one point pair per cycle, limited by the single read port of
// the point memory (one read per point, registered read data), then, when the
// target falls strictly inside a pair, runs a serial divide and a multiply.
// An evaluate can be decided on the first pair. Requests are stalled while
// an evaluate is in progress; a finished response waits in the output
// register while the next request is accepted.
module calibrated_feedforward_interpolator #(
   parameter int POINTS_PER_TABLE = cfi_pkg::POINTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_motor_side,
   input  logic        req_table_direction,
   input  logic [3:0]  req_point_index,
   input  logic signed [15:0] req_point_input,
   input  logic signed [15:0] req_point_output,
   input  logic signed [15:0] req_target_speed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_feedforward_value
);

   localparam int DEPTH = cfi_pkg::NUM_TABLES * POINTS_PER_TABLE;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(POINTS_PER_TABLE);
   localparam int VW    = cfi_pkg::VAL_W;
   localparam int QW    = cfi_pkg::QUOT_W;
   localparam int PW    = 2 * (VW + 1);
   localparam logic [AW-1:0] P_A    = AW'(POINTS_PER_TABLE);
   localparam logic [IW-1:0] LAST_I = IW'(POINTS_PER_TABLE - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_FIRST, S_WALK, S_DIV, S_SUM, S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic signed [VW-1:0]     t_ff, t_in;
   logic [AW-1:0]            base_ff, base_in;
   logic [IW-1:0]            idx_ff, idx_in;
   cfi_pkg::point_type       pa_ff, pa_in;
   cfi_pkg::point_type       pb_ff, pb_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [VW-1:0]     res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]     rsp_value_ff, rsp_value_in;

   logic                     st_we;
   logic [AW-1:0]            st_waddr;
   cfi_pkg::point_type       st_wdata;
   logic [AW-1:0]            st_raddr;
   cfi_pkg::point_type       st_rdata;

   cfi_pkg::div_req_type     div_req;
   logic                     div_done;
   logic [QW-1:0]            div_quot;

   logic [1:0]               load_tbl;
   logic [1:0]               eval_tbl;
   logic [IW-1:0]            idx_nxt;
   logic signed [VW:0]       num_w;
   logic signed [VW:0]       den_w;
   logic signed [VW:0]       ddrive_w;
   logic signed [PW-1:0]     prod_w;
   logic signed [PW-1:0]     adj_w;
   logic signed [PW-1:0]     delta_w;

   cfi_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   cfi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign load_tbl = {req_motor_side, req_table_direction};
   assign eval_tbl = {req_motor_side, (req_target_speed > 16'sd0) ? 1'b0 : 1'b1};
   assign idx_nxt  = idx_ff + IW'(1);
   assign num_w    = (VW+1)'(t_ff) - (VW+1)'(pa_ff.speed);
   assign den_w    = (VW+1)'(st_rdata.speed) - (VW+1)'(pa_ff.speed);
   assign ddrive_w = (VW+1)'(pb_ff.drive) - (VW+1)'(pa_ff.drive);
   assign prod_w   = $signed({1'b0, div_quot}) * ddrive_w;
   assign adj_w    = prod_ff + (prod_ff[PW-1] ? PW'(65535) : PW'(0));
   assign delta_w  = adj_w >>> QW;

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_value_in = rsp_value_ff;
      st_we        = 1'b0;
      st_waddr     = AW'(load_tbl) * P_A + AW'(req_point_index);
      st_wdata     = {req_point_output, req_point_input};
      st_raddr     = base_ff;
      div_req      = '{start: 1'b0, num: num_w[QW-1:0], den: den_w[QW-1:0]};
      case (state_ff)
         S_IDLE: begin
            st_raddr = AW'(eval_tbl) * P_A;
            if (req_valid) begin
               if (req_command == cfi_pkg::CMD_LOAD) begin
                  st_we = int'(req_point_index) < POINTS_PER_TABLE;
               end else begin
                  t_in     = req_target_speed;
                  base_in  = AW'(eval_tbl) * P_A;
                  idx_in   = IW'(1);
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            pa_in    = st_rdata;
            st_raddr = base_ff + AW'(idx_ff);
            state_in = S_WALK;
         end
         S_WALK: begin
            st_raddr = base_ff + AW'(idx_nxt);
            if (t_ff < pa_ff.speed) begin
               res_in   = '0;
               state_in = S_OUT;
            end else if (t_ff <= st_rdata.speed) begin
               pb_in = st_rdata;
               if (t_ff == pa_ff.speed) begin
                  res_in   = pa_ff.drive;
                  state_in = S_OUT;
               end else if (t_ff == st_rdata.speed) begin
                  res_in   = st_rdata.drive;
                  state_in = S_OUT;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end else if (idx_ff == LAST_I) begin
               res_in   = '0;
               state_in = S_OUT;
            end else begin
               pa_in  = st_rdata;
               idx_in = idx_nxt;
            end
         end
         S_DIV: begin
            if (div_done) begin
               prod_in  = prod_w;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            res_in   = pa_ff.drive + delta_w[VW-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      t_ff         <= t_in;
      base_ff      <= base_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_feedforward_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      st_we |-> state_ff == S_IDLE)
      else $error("point write outside idle");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished with no divide pending");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> idx_ff != '0 && idx_ff <= LAST_I)
      else $error("walk index out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output state");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> t_ff > pa_ff.speed && t_ff < st_rdata.speed)
      else $error("divide started outside an open segment");
`endif

endmodule

// ===== design/cfi_store.sv =====
// Calibration point memory: one write port, one read port, registered read data.
// Depends on cfi_pkg.
module cfi_store #(
   parameter int DEPTH = 4 * cfi_pkg::POINTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  cfi_pkg::point_type  wdata,
   input  logic [AW-1:0]       raddr,
   output cfi_pkg::point_type  rdata
);

   cfi_pkg::point_type mem [DEPTH];
   cfi_pkg::point_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/cfi_div.sv =====
// Restoring divider, one quotient bit per cycle: quot = (num << QUOT_W) / den.
// Requires num < den. Depends on cfi_pkg.
module cfi_div (
   input  logic                         clock,
   input  logic                         reset,
   input  cfi_pkg::div_req_type         req,
   output logic                         done,
   output logic [cfi_pkg::QUOT_W-1:0]   quot
);

   localparam int QW = cfi_pkg::QUOT_W;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] den_ff, den_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [QW:0]   shifted;
   logic [QW:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      if (req.start) begin
         rem_in  = req.num;
         den_in  = req.den;
         quot_in = '0;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = diff[QW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = shifted[QW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
